// File: sv/rpo_pkg.sv
// Shared types, constants and register codes for the RGB pixel point-operation block.
package rpo_pkg;

   localparam int CHAN_W   = 8;
   localparam int REG_W    = 9;
   localparam int NUM_REGS = 8;
   localparam int IDX_W    = $clog2(NUM_REGS);
   localparam int GAIN_W   = 24;
   localparam int LUMA_W   = 24;

   // register indexes
   localparam logic [IDX_W-1:0] IDX_MODE        = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_LEVEL       = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_OFFSET      = IDX_W'(2);
   localparam logic [IDX_W-1:0] IDX_SAT_ALPHA   = IDX_W'(3);
   localparam logic [IDX_W-1:0] IDX_SOLAR_RED   = IDX_W'(4);
   localparam logic [IDX_W-1:0] IDX_SOLAR_GREEN = IDX_W'(5);
   localparam logic [IDX_W-1:0] IDX_SOLAR_BLUE  = IDX_W'(6);
   localparam logic [IDX_W-1:0] IDX_SOLAR_GRAY  = IDX_W'(7);

   // operation codes
   localparam logic [3:0] MODE_AVG       = 4'd0;
   localparam logic [3:0] MODE_LUMA      = 4'd1;
   localparam logic [3:0] MODE_INVERT    = 4'd2;
   localparam logic [3:0] MODE_SWAP      = 4'd3;
   localparam logic [3:0] MODE_THRESH    = 4'd4;
   localparam logic [3:0] MODE_BRIGHT    = 4'd5;
   localparam logic [3:0] MODE_CONTRAST  = 4'd6;
   localparam logic [3:0] MODE_CON_BRITE = 4'd7;
   localparam logic [3:0] MODE_SATURATE  = 4'd8;
   localparam logic [3:0] MODE_SOLARIZE  = 4'd9;
   localparam logic [3:0] MODE_SEPIA     = 4'd10;

   // reset values
   localparam logic [REG_W-1:0]  ALPHA_ONE   = 9'd256;
   localparam logic [REG_W-1:0]  SOLAR_RESET = 9'd128;
   localparam logic [GAIN_W-1:0] GAIN_RESET  = 24'd65536;

   // luma weights Q0.16, index 0 = red
   localparam logic [2:0][15:0] LUMA_WT = {16'd3887, 16'd44433, 16'd17216};
   // sepia weights Q0.16, [output channel][input channel]
   localparam logic [2:0][2:0][15:0] SEPIA_WT = {
      {16'd8585,  16'd34996, 16'd17826},
      {16'd11010, 16'd44958, 16'd22872},
      {16'd12386, 16'd50397, 16'd25756}
   };
   // floor(s/3) = (s*683) >> 11 for s <= 765
   localparam logic [9:0] AVG_RECIP = 10'd683;
   localparam int         AVG_SHIFT = 11;

   // contrast gain divider
   localparam int DIV_STEPS = 34;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [2:0] rgb_type;

   typedef struct packed {
      logic [3:0]             mode;
      logic [REG_W-1:0]       level;
      logic [REG_W-1:0]       offset;
      logic [REG_W-1:0]       sat_alpha;
      logic [2:0][REG_W-1:0]  solar_limit;
      logic                   solar_to_gray;
      logic [GAIN_W-1:0]      gain;
   } cfg_type;

endpackage

// File: sv/rpo_gain_div.sv
// Contrast gain divider: restoring division, one quotient bit per cycle.
module rpo_gain_div
   import rpo_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [REG_W-1:0]     level,
   output logic                 busy,
   output logic [GAIN_W-1:0]    gain
);

   logic                  run_ff, run_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [16:0]           rem_ff, rem_in;
   logic [33:0]           quo_ff, quo_in;
   logic [16:0]           den_ff, den_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;

   logic signed [8:0]     amt;
   logic [8:0]            apos;
   logic [17:0]           num;
   logic [9:0]            dm;
   logic [17:0]           shifted;
   logic [18:0]           diff;
   logic                  ok;

   always_comb begin
      // -256 behaves like -255 (gain 0)
      amt     = (level == 9'h100) ? -9'sd255 : $signed(level);
      apos    = 9'($signed({amt[8], amt}) + 10'sd255);
      num     = 18'(apos) * 18'd259;
      dm      = 10'(10'sd259 - $signed({amt[8], amt}));
      den_in  = 17'(dm) * 17'd255;

      shifted = {rem_ff, quo_ff[33]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      ok      = !diff[18];

      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      gain_in = gain_ff;
      if (load) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = {num, 16'b0};
      end else if (run_ff) begin
         rem_in = ok ? diff[16:0] : shifted[16:0];
         quo_in = {quo_ff[32:0], ok};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            gain_in = quo_in[GAIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         gain_ff <= GAIN_RESET;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (load) begin
         den_ff <= den_in;
      end
   end

   assign busy = run_ff;
   assign gain = gain_ff;

endmodule

// File: sv/rpo_datapath.sv
// Five-stage pixel datapath: solarize, products, sums and clamps, blend products, output.
module rpo_datapath
   import rpo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  chan_type   in_red,
   input  chan_type   in_green,
   input  chan_type   in_blue,
   input  cfg_type    cfg,
   output logic       out_valid,
   output chan_type   out_red,
   output chan_type   out_green,
   output chan_type   out_blue
);

   typedef struct packed {
      rgb_type     raw;
      rgb_type     sol;
      logic [9:0]  sum;
   } s1_type;

   typedef struct packed {
      rgb_type                  raw;
      rgb_type                  sol;
      rgb_type                  bright;
      logic [2:0][23:0]         luma_p;
      logic [2:0][2:0][23:0]    sepia_p;
      logic [2:0][33:0]         con_p;
      logic [19:0]              avg_p;
   } s2_type;

   typedef struct packed {
      rgb_type           raw;
      rgb_type           sol;
      rgb_type           bright;
      rgb_type           sepia;
      rgb_type           con;
      chan_type          avg;
      logic [LUMA_W-1:0] y;
   } s3_type;

   typedef struct packed {
      rgb_type           other;
      logic              is_sat;
      logic [32:0]       ya;
      logic [2:0][15:0]  xa;
   } s4_type;

   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   rgb_type out_ff, out_in;

   // stage 1: capture, solarize per channel, channel sum
   always_comb begin
      s1_in.raw[0] = in_red;
      s1_in.raw[1] = in_green;
      s1_in.raw[2] = in_blue;
      for (int i = 0; i < 3; i++) begin
         s1_in.sol[i] = ({1'b0, s1_in.raw[i]} < cfg.solar_limit[i]) ?
                        ~s1_in.raw[i] : s1_in.raw[i];
      end
      s1_in.sum = 10'(in_red) + 10'(in_green) + 10'(in_blue);
   end

   // stage 2: constant and gain products, brightness
   always_comb begin
      rgb_type            lsrc;
      logic signed [24:0] gs;
      logic signed [8:0]  xm;
      logic signed [33:0] prod;
      logic signed [9:0]  bv;
      lsrc = (cfg.mode == MODE_SOLARIZE) ? s1_ff.sol : s1_ff.raw;
      gs   = $signed({1'b0, cfg.gain});
      s2_in.raw = s1_ff.raw;
      s2_in.sol = s1_ff.sol;
      for (int i = 0; i < 3; i++) begin
         s2_in.luma_p[i] = 24'(LUMA_WT[i]) * 24'(lsrc[i]);
         for (int j = 0; j < 3; j++) begin
            s2_in.sepia_p[i][j] = 24'(SEPIA_WT[i][j]) * 24'(s1_ff.raw[j]);
         end
         xm   = $signed({1'b0, s1_ff.raw[i]} - 9'd128);
         prod = gs * xm;
         s2_in.con_p[i] = prod;
         bv = $signed({2'b00, s1_ff.raw[i]}) + $signed({cfg.level[8], cfg.level});
         s2_in.bright[i] = bv[9] ? 8'd0 : (bv[8] ? 8'd255 : bv[7:0]);
      end
      s2_in.avg_p = 20'(s1_ff.sum) * 20'(AVG_RECIP);
   end

   // stage 3: luma and sepia sums, contrast bias and clamp
   always_comb begin
      logic [24:0]        ssum;
      logic [REG_W-1:0]   b;
      logic signed [9:0]  bsum;
      logic signed [33:0] bias;
      logic signed [33:0] v;
      s3_in.raw    = s2_ff.raw;
      s3_in.sol    = s2_ff.sol;
      s3_in.bright = s2_ff.bright;
      s3_in.y      = s2_ff.luma_p[0] + s2_ff.luma_p[1] + s2_ff.luma_p[2];
      s3_in.avg    = s2_ff.avg_p[AVG_SHIFT +: CHAN_W];
      b    = (cfg.mode == MODE_CON_BRITE) ? cfg.offset : '0;
      bsum = $signed({b[8], b}) + 10'sd128;
      bias = {{8{bsum[9]}}, bsum, 16'b0};
      for (int i = 0; i < 3; i++) begin
         ssum = 25'(s2_ff.sepia_p[i][0]) + 25'(s2_ff.sepia_p[i][1])
              + 25'(s2_ff.sepia_p[i][2]);
         s3_in.sepia[i] = ssum[24] ? 8'd255 : ssum[23:16];
         v = $signed(s2_ff.con_p[i]) + bias;
         if (v[33]) begin
            s3_in.con[i] = 8'd0;
         end else if (|v[32:24]) begin
            s3_in.con[i] = 8'd255;
         end else begin
            s3_in.con[i] = v[23:16];
         end
      end
   end

   // stage 4: mode select, saturation blend products
   always_comb begin
      logic [REG_W-1:0] a;
      chan_type         gray;
      chan_type         thr;
      a    = (cfg.sat_alpha[8] && (|cfg.sat_alpha[7:0])) ? ALPHA_ONE : cfg.sat_alpha;
      gray = s3_ff.y[23:16];
      if (cfg.level[8]) begin
         thr = 8'd255;
      end else begin
         thr = ({1'b0, gray} >= cfg.level) ? 8'd255 : 8'd0;
      end
      s4_in.ya     = 33'(s3_ff.y) * 33'(ALPHA_ONE - a);
      s4_in.is_sat = (cfg.mode == MODE_SATURATE);
      for (int i = 0; i < 3; i++) begin
         s4_in.xa[i] = 16'(s3_ff.raw[i]) * 16'(a);
      end
      case (cfg.mode)
         MODE_AVG:       s4_in.other = {3{s3_ff.avg}};
         MODE_LUMA:      s4_in.other = {3{gray}};
         MODE_INVERT:    s4_in.other = ~s3_ff.raw;
         MODE_SWAP:      s4_in.other = {s3_ff.raw[0], s3_ff.raw[1], s3_ff.raw[2]};
         MODE_THRESH:    s4_in.other = {3{thr}};
         MODE_BRIGHT:    s4_in.other = s3_ff.bright;
         MODE_CONTRAST,
         MODE_CON_BRITE: s4_in.other = s3_ff.con;
         MODE_SOLARIZE:  s4_in.other = cfg.solar_to_gray ? {3{gray}} : s3_ff.sol;
         MODE_SEPIA:     s4_in.other = s3_ff.sepia;
         default:        s4_in.other = s3_ff.raw;
      endcase
   end

   // stage 5: blend sum and final pick
   always_comb begin
      logic [32:0] bsum;
      for (int i = 0; i < 3; i++) begin
         bsum = s4_ff.ya + {1'b0, s4_ff.xa[i], 16'b0};
         out_in[i] = s4_ff.is_sat ? bsum[31:24] : s4_ff.other[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s4_ff  <= s4_in;
      out_ff <= out_in;
   end

   assign out_valid = v5_ff;
   assign out_red   = out_ff[0];
   assign out_green = out_ff[1];
   assign out_blue  = out_ff[2];

endmodule

// File: sv/rgb_pixel_point_ops.sv
// RGB888 point-operation block: config registers, gain divider and pixel pipeline.
//
// One pixel is taken per clock while busy is low (start high, busy low) and its
// processed word appears on the rsp_ ports after the five register stages of the
// pixel pipeline, marked by rsp_valid for one cycle; the receiver cannot stall the
// output. A write to the level register starts the contrast gain divider, which
// resolves one quotient bit per cycle and holds busy high until the divide is
// done; busy is also high during reset.
// Write registers only when no pixel is in flight.
module rgb_pixel_point_ops
   import rpo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [7:0]        req_red_in,
   input  logic [7:0]        req_green_in,
   input  logic [7:0]        req_blue_in,
   output logic              rsp_valid,
   output logic [7:0]        rsp_red_out,
   output logic [7:0]        rsp_green_out,
   output logic [7:0]        rsp_blue_out,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]  csr_wdata
);

   logic [3:0]            mode_ff;
   logic [REG_W-1:0]      level_ff;
   logic [REG_W-1:0]      offset_ff;
   logic [REG_W-1:0]      alpha_ff;
   logic [2:0][REG_W-1:0] limit_ff;
   logic                  to_gray_ff;

   logic                  div_busy;
   logic [GAIN_W-1:0]     gain;
   logic                  level_wr;
   cfg_type               cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_LUMA;
         level_ff   <= '0;
         offset_ff  <= '0;
         alpha_ff   <= ALPHA_ONE;
         limit_ff   <= {3{SOLAR_RESET}};
         to_gray_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            IDX_MODE:        mode_ff     <= csr_wdata[3:0];
            IDX_LEVEL:       level_ff    <= csr_wdata;
            IDX_OFFSET:      offset_ff   <= csr_wdata;
            IDX_SAT_ALPHA:   alpha_ff    <= csr_wdata;
            IDX_SOLAR_RED:   limit_ff[0] <= csr_wdata;
            IDX_SOLAR_GREEN: limit_ff[1] <= csr_wdata;
            IDX_SOLAR_BLUE:  limit_ff[2] <= csr_wdata;
            IDX_SOLAR_GRAY:  to_gray_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign level_wr = csr_we && (csr_index == IDX_LEVEL) && !reset;

   rpo_gain_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (level_wr),
      .level (csr_wdata),
      .busy  (div_busy),
      .gain  (gain)
   );

   always_comb begin
      cfg.mode          = mode_ff;
      cfg.level         = level_ff;
      cfg.offset        = offset_ff;
      cfg.sat_alpha     = alpha_ff;
      cfg.solar_limit   = limit_ff;
      cfg.solar_to_gray = to_gray_ff;
      cfg.gain          = gain;
   end

   assign busy = reset || div_busy;

   rpo_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_red    (req_red_in),
      .in_green  (req_green_in),
      .in_blue   (req_blue_in),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_red   (rsp_red_out),
      .out_green (rsp_green_out),
      .out_blue  (rsp_blue_out)
   );

endmodule

// File: sv/rpo_checker.sv
// Port-level checks for the point-operation block, bound to the top level.
module rpo_checker
   import rpo_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             csr_we,
   input logic [IDX_W-1:0] csr_index
);

   // rsp_valid tracks the accepted words, delayed by the pixel pipeline registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy, 5))
      else $error("rsp_valid does not match accepts five cycles earlier");

   a_busy_after_level: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == IDX_LEVEL) |=> busy)
      else $error("busy not raised after level write");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      ($rose(busy) && !$past(reset)) |-> $past(csr_we && csr_index == IDX_LEVEL))
      else $error("busy rose without a level write");

   a_busy_length: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(busy, DIV_STEPS))
      else $error("busy dropped before the gain divide finished");

endmodule

bind rgb_pixel_point_ops rpo_checker u_rpo_checker (.*);
